FILE: sv/raid_parity_check_and_rebuild_core_assert.svh
// Assertion macros used by the checker of the parity check and rebuild core.
// Each macro names the clock and reset ports of the module that uses it.
`ifndef RAID_PARITY_CHECK_AND_REBUILD_CORE_ASSERT_SVH
`define RAID_PARITY_CHECK_AND_REBUILD_CORE_ASSERT_SVH

// Same-cycle implication, or any property, checked outside reset.
`define RPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: sv/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and helpers of the parity check and rebuild core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

  localparam int MAX_DISKS      = 8;
  localparam int MAX_BLOCK_BITS = 64;
  localparam int DISK_W         = $clog2(MAX_DISKS);        // disk number
  localparam int DCNT_W         = DISK_W + 1;               // disk count 0..8
  localparam int COL_W          = $clog2(MAX_BLOCK_BITS);   // column index
  localparam int SLEN_W         = COL_W + 1;                // block length 0..64
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;
  localparam int DC_REG_W       = 4;
  localparam int QUEUE_DEPTH    = 2;                        // power of two
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = QPTR_W + 1;

  localparam logic [DC_REG_W-1:0]   DISK_COUNT_RST = 4'd3;
  localparam logic [SLEN_W-1:0]     BLOCK_BITS_RST = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISK_COUNT = 2'd0,
    CFG_ODD_PARITY = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DC_REG_W-1:0] disk_count;
    logic                odd_parity;
    logic [SLEN_W-1:0]   bits_per_block;
  } cfg_t;

  // one lane per disk, one bit per column
  typedef logic [MAX_DISKS-1:0][MAX_BLOCK_BITS-1:0] stripe_t;

  // finished block handed from the column side to the emitter
  typedef struct packed {
    stripe_t             stripe;
    logic [DISK_W-1:0]   parity_disk;
    logic [DCNT_W-1:0]   disks;
    logic [SLEN_W-1:0]   block_bits;
    logic                invalid;
  } blk_t;

  function automatic logic [DCNT_W-1:0] eff_disks(input logic [DC_REG_W-1:0] dc);
    logic [DCNT_W-1:0] d;
    d = DCNT_W'(dc);
    if (dc < DC_REG_W'(2)) d = DCNT_W'(2);
    if (dc > DC_REG_W'(MAX_DISKS)) d = DCNT_W'(MAX_DISKS);
    return d;
  endfunction

  function automatic logic [SLEN_W-1:0] eff_block_bits(input logic [SLEN_W-1:0] bpb);
    logic [SLEN_W-1:0] s;
    s = bpb;
    if (bpb == '0) s = SLEN_W'(1);
    if (bpb > SLEN_W'(MAX_BLOCK_BITS)) s = SLEN_W'(MAX_BLOCK_BITS);
    return s;
  endfunction

  // pd mod d for a narrow pd and d >= 2: a few compare-subtract steps
  function automatic logic [DISK_W-1:0] mod_disks(input logic [DISK_W-1:0] pd,
                                                  input logic [DCNT_W-1:0] d);
    logic [DCNT_W-1:0] r;
    r = DCNT_W'(pd);
    for (int k = 0; k < MAX_DISKS / 2; k++) begin
      if (r >= d) r = r - d;
    end
    return r[DISK_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rpc_in_if.sv
// ----------------------------------------------------------------------------
// rpc_in_if
// Column channel: one bit column across the disk set per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpc_in_if;
  import rpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MAX_DISKS-1:0] col_bits;
  logic [MAX_DISKS-1:0] erased_mask;
  logic                 set_start;

  modport source (output valid, output col_bits, output erased_mask, output set_start,
                  input ready);
  modport sink   (input valid, input col_bits, input erased_mask, input set_start,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/rpc_out_if.sv
// ----------------------------------------------------------------------------
// rpc_out_if
// Word channel: one data disk's block bits per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpc_out_if;
  import rpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MAX_BLOCK_BITS-1:0] disk_word;
  logic [DISK_W-1:0]         disk_number;
  logic                      set_invalid;
  logic                      last;

  modport source (output valid, output disk_word, output disk_number, output set_invalid,
                  output last, input ready);
  modport sink   (input valid, input disk_word, input disk_number, input set_invalid,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: sv/rpc_queue.sv
// ----------------------------------------------------------------------------
// rpc_queue
// Short block queue between the column front end and the word emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  rpc_pkg::blk_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rpc_pkg::blk_t      data_o
);
  import rpc_pkg::*;

  blk_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = wptr_q + QPTR_W'(1);
    if (pop_i)  rptr_d = rptr_q + QPTR_W'(1);
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rpc_front.sv
// ----------------------------------------------------------------------------
// rpc_front
// Column front end: parity check, single-erasure repair, stripe buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  rpc_pkg::cfg_t      cfg_i,
  rpc_in_if.sink             in_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output rpc_pkg::blk_t      blk_o
);
  import rpc_pkg::*;

  stripe_t             stripe_q;
  logic [COL_W-1:0]    col_idx_q, col_idx_d;
  logic [DISK_W-1:0]   pd_q, pd_d;
  logic                inv_q, inv_d;

  logic [DCNT_W-1:0]    d;
  logic [SLEN_W-1:0]    s;
  logic [MAX_DISKS-1:0] active, bits, erased, col;
  logic [DCNT_W-1:0]    nerased;
  logic                 par_err, bad, accept, blk_end;
  logic [COL_W-1:0]     idx;
  logic [DISK_W-1:0]    pd_base, pd;
  stripe_t              stripe_next;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    d = eff_disks(cfg_i.disk_count);
    s = eff_block_bits(cfg_i.bits_per_block);
    for (int k = 0; k < MAX_DISKS; k++) begin
      active[k] = (DCNT_W'(k) < d);
    end
    bits    = in_i.col_bits & active;
    erased  = in_i.erased_mask & active;
    nerased = '0;
    for (int k = 0; k < MAX_DISKS; k++) begin
      nerased = nerased + DCNT_W'(erased[k]);
    end
    col     = bits & ~erased;
    par_err = (^col) ^ cfg_i.odd_parity;
    bad     = 1'b0;
    if (nerased == '0) begin
      bad = par_err;
    end else if (nerased == DCNT_W'(1)) begin
      if (par_err) col = col | erased;   // rebuild the missing bit
    end else begin
      bad = 1'b1;                        // unrecoverable, erased bits stay 0
    end

    // a new set restarts position, parity rotation and the sticky flag
    idx     = in_i.set_start ? '0   : col_idx_q;
    pd_base = in_i.set_start ? '0   : pd_q;
    inv_d   = (in_i.set_start ? 1'b0 : inv_q) | bad;

    blk_end = ((SLEN_W'(idx) + SLEN_W'(1)) >= s);
    pd      = mod_disks(pd_base, d);

    if (blk_end) begin
      col_idx_d = '0;
      pd_d      = ((DCNT_W'(pd) + DCNT_W'(1)) >= d) ? '0 : pd + DISK_W'(1);
    end else begin
      col_idx_d = idx + COL_W'(1);
      pd_d      = pd_base;
    end

    stripe_next = stripe_q;
    for (int k = 0; k < MAX_DISKS; k++) begin
      stripe_next[k][idx] = col[k];
    end
  end

  assign push_o            = accept && blk_end;
  assign blk_o.stripe      = stripe_next;
  assign blk_o.parity_disk = pd;
  assign blk_o.disks       = d;
  assign blk_o.block_bits  = s;
  assign blk_o.invalid     = inv_d;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < MAX_DISKS; k++) begin
        stripe_q[k][idx] <= col[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_idx_q <= '0;
      pd_q      <= '0;
      inv_q     <= 1'b0;
    end else if (accept) begin
      col_idx_q <= col_idx_d;
      pd_q      <= pd_d;
      inv_q     <= inv_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rpc_back.sv
// ----------------------------------------------------------------------------
// rpc_back
// Word emitter: one data disk word per cycle off the queue head while ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  rpc_pkg::blk_t      head_i,
  output logic               pop_o,
  rpc_out_if.source          out_o
);
  import rpc_pkg::*;

  logic [DISK_W-1:0]         disk_q, disk_d;
  logic                      vld_q;
  logic [MAX_BLOCK_BITS-1:0] word_q;
  logic [DISK_W-1:0]         num_q;
  logic                      inv_q, last_q;

  logic [DCNT_W-1:0]         cur, nxt, nxt_skip;
  logic                      last, load;
  logic [MAX_BLOCK_BITS-1:0] tword, word;
  logic [COL_W-1:0]          sh;

  always_comb begin
    // skip the block's parity disk
    cur = (disk_q == head_i.parity_disk) ? DCNT_W'(disk_q) + DCNT_W'(1) : DCNT_W'(disk_q);
    nxt = cur + DCNT_W'(1);
    nxt_skip = (!nxt[DISK_W] && nxt[DISK_W-1:0] == head_i.parity_disk) ?
               nxt + DCNT_W'(1) : nxt;
    last = (nxt_skip >= head_i.disks);
    // first column lands in the top bit, then right-align to the block length
    for (int i = 0; i < MAX_BLOCK_BITS; i++) begin
      tword[MAX_BLOCK_BITS-1-i] = head_i.stripe[cur[DISK_W-1:0]][i];
    end
    sh   = COL_W'(SLEN_W'(MAX_BLOCK_BITS) - head_i.block_bits);
    word = tword >> sh;
    disk_d = last ? '0 : nxt[DISK_W-1:0];
  end

  assign load  = head_valid_i && (!vld_q || out_o.ready);
  assign pop_o = load && last;

  assign out_o.valid       = vld_q;
  assign out_o.disk_word   = word_q;
  assign out_o.disk_number = num_q;
  assign out_o.set_invalid = inv_q;
  assign out_o.last        = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word;
      num_q  <= cur[DISK_W-1:0];
      inv_q  <= head_i.invalid;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      disk_q <= '0;
    end else begin
      if (load) begin
        vld_q  <= 1'b1;
        disk_q <= disk_d;
      end else if (out_o.ready) begin
        vld_q  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/raid_parity_check_and_rebuild_core.sv
// A block is registered in the queue, each word then in the output register. Throughput:
// one column per cycle; the emitter sends one word per cycle while out_o.ready is high,
// disk count - 1 words per block, and two finished blocks can queue before columns stall.
// Reset: asynchronous, active low; clears position, parity rotation, invalid flag, queue
// and output valid; configuration returns to 3 disks, even parity, 8 bits per block.
// ----------------------------------------------------------------------------
// raid_parity_check_and_rebuild_core
// RAID XOR parity check with single-erasure rebuild and per-disk block output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raid_parity_check_and_rebuild_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rpc_in_if.sink                                 in_i,
  rpc_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rpc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import rpc_pkg::*;

  cfg_t cfg_q;
  logic q_full, push, pop, head_valid;
  blk_t blk_in, blk_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disk_count     <= DISK_COUNT_RST;
      cfg_q.odd_parity     <= 1'b0;
      cfg_q.bits_per_block <= BLOCK_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DISK_COUNT: cfg_q.disk_count     <= cfg_wdata_i[DC_REG_W-1:0];
        CFG_ODD_PARITY: cfg_q.odd_parity     <= cfg_wdata_i[0];
        CFG_BLOCK_BITS: cfg_q.bits_per_block <= cfg_wdata_i[SLEN_W-1:0];
        default: ;
      endcase
    end
  end

  rpc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .blk_o    (blk_in)
  );

  rpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (blk_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (blk_head)
  );

  rpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (blk_head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

FILE: sv/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks on the word channel of the parity check and rebuild core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "raid_parity_check_and_rebuild_core_assert.svh"

module rpc_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 out_valid_i,
  input wire logic                                 out_ready_i,
  input wire logic [rpc_pkg::MAX_BLOCK_BITS-1:0]   out_word_i,
  input wire logic [rpc_pkg::DISK_W-1:0]           out_disk_i,
  input wire logic                                 out_inv_i,
  input wire logic                                 out_last_i
);
  import rpc_pkg::*;

  localparam logic [DISK_W-1:0] TOP_DISK = DISK_W'(MAX_DISKS - 1);

  // a stalled word holds
  `RPC_ASSERT_NEXT(a_word_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i) && $stable(out_disk_i) && $stable(out_inv_i) && $stable(out_last_i), "stalled word changed")

  // the highest disk number can only close a block
  `RPC_ASSERT(a_top_disk_last, out_valid_i && out_disk_i == TOP_DISK |-> out_last_i, "top disk word not marked last")

  // within a block the next word follows at once, from a higher disk
  `RPC_ASSERT_NEXT(a_block_words, out_valid_i && out_ready_i && !out_last_i, out_valid_i && out_disk_i > $past(out_disk_i), "block words not contiguous or ascending")

  // nothing can be pending right after reset
  `RPC_ASSERT(a_quiet_after_reset, $rose(rst_ni) |-> !out_valid_i, "word valid right after reset")

endmodule

bind raid_parity_check_and_rebuild_core rpc_checker u_rpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.disk_word),
  .out_disk_i  (out_o.disk_number),
  .out_inv_i   (out_o.set_invalid),
  .out_last_i  (out_o.last)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bit columns into the parity check and rebuild core and checks every
// disk word against a cycle-free model of the core kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rpc_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_GAP        = 13;
  localparam int RANDOM_COLUMNS = 240;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 10;

  // index outside the register map, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [MAX_BLOCK_BITS-1:0] word;
    logic [DISK_W-1:0]         disk;
    logic                      invalid;
    logic                      last;
  } disk_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rpc_in_if  in_if ();
  rpc_out_if out_if ();

  raid_parity_check_and_rebuild_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // model state
  logic [MAX_DISKS-1:0] stripe_rows [MAX_BLOCK_BITS];
  logic [COL_W-1:0]     col_pos;
  logic [DISK_W-1:0]    parity_pos;
  logic                 set_bad;
  logic [DC_REG_W-1:0]  disk_count_reg;
  logic                 odd_reg;
  logic [SLEN_W-1:0]    block_bits_reg;

  disk_word_t words_due [$];

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  random_cols = 0;
  bit  tx_burst    = 1'b0;
  bit  rx_burst    = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned disks_in_use();
    if (disk_count_reg < 2) return 2;
    if (disk_count_reg > MAX_DISKS) return MAX_DISKS;
    return disk_count_reg;
  endfunction

  function automatic int unsigned block_len();
    if (block_bits_reg == 0) return 1;
    if (block_bits_reg > MAX_BLOCK_BITS) return MAX_BLOCK_BITS;
    return block_bits_reg;
  endfunction

  function automatic logic [MAX_DISKS-1:0] active_disks();
    return MAX_DISKS'((9'h1 << disks_in_use()) - 9'h1);
  endfunction

  // Update the model with one accepted column, queue the words it releases.
  function automatic void predict_column(input logic [MAX_DISKS-1:0] bits,
                                         input logic [MAX_DISKS-1:0] erased,
                                         input logic start);
    int unsigned          d;
    int unsigned          s;
    int unsigned          p;
    logic [MAX_DISKS-1:0] er;
    logic [MAX_DISKS-1:0] col;
    disk_word_t           w;
    d   = disks_in_use();
    s   = block_len();
    er  = erased & active_disks();
    col = bits & active_disks() & ~er;
    if (start) begin
      col_pos    = '0;
      parity_pos = '0;
      set_bad    = 1'b0;
    end
    if ($countones(er) == 0) begin
      if ((^col) != odd_reg) set_bad = 1'b1;
    end else if ($countones(er) == 1) begin
      if ((^col) ^ odd_reg) col = col | er;
    end else begin
      set_bad = 1'b1;
    end
    stripe_rows[col_pos] = col;
    if (int'(col_pos) + 1 >= int'(s)) begin
      p = parity_pos % d;
      for (int j = 0; j < int'(d); j++) begin
        if (j != int'(p)) begin
          w.word = '0;
          for (int i = 0; i < int'(s); i++) w.word = {w.word[MAX_BLOCK_BITS-2:0], stripe_rows[i][j]};
          w.disk    = DISK_W'(j);
          w.invalid = set_bad;
          w.last    = 1'b0;
          words_due.push_back(w);
        end
      end
      words_due[words_due.size()-1].last = 1'b1;
      col_pos    = '0;
      parity_pos = (p + 1 >= d) ? '0 : DISK_W'(p + 1);
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // Mostly consistent columns, some rebuilds, some broken ones; junk above the set.
  function automatic void make_column(output logic [MAX_DISKS-1:0] bits,
                                      output logic [MAX_DISKS-1:0] erased);
    int unsigned d;
    int unsigned kind;
    int unsigned k1;
    int unsigned k2;
    d      = disks_in_use();
    bits   = MAX_DISKS'($urandom);
    erased = MAX_DISKS'($urandom) & ~active_disks();
    kind   = $urandom_range(0, 9);
    k1     = $urandom_range(0, d - 1);
    k2     = (k1 + $urandom_range(1, d - 1)) % d;
    if (kind <= 5) begin
      if ((^(bits & active_disks())) != odd_reg) bits = bits ^ MAX_DISKS'(1 << k1);
    end else if (kind <= 7) begin
      erased = erased | MAX_DISKS'(1 << k1);
    end else if (kind == 8) begin
      erased = erased | MAX_DISKS'(1 << k1) | MAX_DISKS'(1 << k2)
             | (MAX_DISKS'($urandom) & active_disks());
    end else begin
      erased = MAX_DISKS'($urandom);
    end
  endfunction

  task automatic send_column(input logic [MAX_DISKS-1:0] bits,
                             input logic [MAX_DISKS-1:0] erased,
                             input logic start);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.col_bits    <= bits;
    in_if.erased_mask <= erased;
    in_if.set_start   <= start;
    do @(posedge clk); while (!in_if.ready);
    predict_column(bits, erased, start);
  endtask

  task automatic send_random(input logic start);
    logic [MAX_DISKS-1:0] bits;
    logic [MAX_DISKS-1:0] erased;
    make_column(bits, erased);
    send_column(bits, erased, start);
  endtask

  // Sender goes quiet until every pending word is out and the core has settled.
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DISK_COUNT: disk_count_reg = data[DC_REG_W-1:0];
      CFG_ODD_PARITY: odd_reg        = data[0];
      CFG_BLOCK_BITS: block_bits_reg = data[SLEN_W-1:0];
      default: ;
    endcase
  endtask

  // Power-on settings: 3 disks, even parity, 8-bit blocks; one block of corner columns.
  task automatic test_reset_defaults();
    send_column(8'h03, 8'h00, 1'b1);
    send_column(8'hF8, 8'h00, 1'b0);  // junk above the set only
    send_column(8'h01, 8'h02, 1'b0);  // rebuilt bit is 1
    send_column(8'h03, 8'h04, 1'b0);  // rebuilt bit is 0
    send_column(8'h06, 8'hF8, 1'b0);  // erasures outside the set ignored
    send_column(8'h01, 8'h00, 1'b0);  // parity mismatch
    send_column(8'h07, 8'h03, 1'b0);  // double erasure
    send_column(8'hFF, 8'hFF, 1'b0);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_DISK_COUNT, 7'd8);
    write_reg(CFG_ODD_PARITY, 7'h41);
    write_reg(CFG_BLOCK_BITS, 7'd1);
    write_reg(CFG_UNMAPPED, 7'h7F);
    send_column(8'h01, 8'h00, 1'b1);
    send_column(8'hFF, 8'h00, 1'b0);
    send_column(8'h80, 8'h80, 1'b1);
    send_column(8'h5A, 8'h00, 1'b0);
    wait_drained();
    write_reg(CFG_DISK_COUNT, 7'd0);
    write_reg(CFG_ODD_PARITY, 7'h7E);
    write_reg(CFG_BLOCK_BITS, 7'd0);
    send_column(8'hFC, 8'h00, 1'b1);
    send_column(8'h01, 8'h01, 1'b0);
    send_column(8'h03, 8'h00, 1'b0);
    wait_drained();
    write_reg(CFG_DISK_COUNT, 7'd9);
    write_reg(CFG_BLOCK_BITS, 7'd2);
    send_random(1'b1);
    send_random(1'b0);
    wait_drained();
  endtask

  // Block length and disk count changed while a block is half done.
  task automatic test_mid_block_changes();
    write_reg(CFG_DISK_COUNT, 7'h72);
    write_reg(CFG_DISK_COUNT, 7'd4);
    write_reg(CFG_BLOCK_BITS, 7'd8);
    send_random(1'b1);
    send_random(1'b0);
    send_random(1'b0);
    wait_drained();
    write_reg(CFG_BLOCK_BITS, 7'd2);   // already past the new end
    send_random(1'b0);
    send_random(1'b0);
    wait_drained();
    write_reg(CFG_BLOCK_BITS, 7'd5);
    repeat (4) send_random(1'b0);
    wait_drained();
    write_reg(CFG_DISK_COUNT, 7'd2);   // parity rotation wraps to the smaller set
    write_reg(CFG_BLOCK_BITS, 7'd1);
    send_random(1'b0);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int   phase;
    int   n;
    int   s;
    int   r;
    logic start;
    phase = 0;
    while (random_cols < RANDOM_COLUMNS) begin
      wait_drained();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        write_reg(CFG_DISK_COUNT, 7'd15);
        write_reg(CFG_BLOCK_BITS, 7'd127);
      end else begin
        if ($urandom_range(0, 2) != 0)
          write_reg(CFG_DISK_COUNT, ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                                                : CFG_DATA_W'($urandom_range(2, 8)));
        if ($urandom_range(0, 1) != 0) write_reg(CFG_ODD_PARITY, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 2) != 0) begin
          r = $urandom_range(0, 19);
          if (r == 0) write_reg(CFG_BLOCK_BITS, CFG_DATA_W'($urandom_range(0, 127)));
          else if (r <= 3) write_reg(CFG_BLOCK_BITS, CFG_DATA_W'($urandom_range(9, 20)));
          else write_reg(CFG_BLOCK_BITS, CFG_DATA_W'($urandom_range(1, 8)));
        end
      end
      s = block_len();
      if (s > 20) n = s;
      else n = s * $urandom_range(1, 3) + ((s > 1 && $urandom_range(0, 2) == 0) ?
                                           $urandom_range(1, s - 1) : 0);
      start = 1'($urandom_range(0, 1));
      for (int k = 0; k < n; k++) begin
        send_random(start);
        start = ($urandom_range(0, 24) == 0);
      end
      random_cols += n;
      phase++;
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // word channel: random stall drawn per word
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  function automatic void note_mismatch(input disk_word_t want, input bit none_due);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (none_due)
        $display("%0t: unexpected word disk %0d word %h invalid %b last %b", $realtime,
                 out_if.disk_number, out_if.disk_word, out_if.set_invalid, out_if.last);
      else
        $display("%0t: mismatch exp disk %0d word %h invalid %b last %b, got disk %0d word %h invalid %b last %b",
                 $realtime, want.disk, want.word, want.invalid, want.last, out_if.disk_number,
                 out_if.disk_word, out_if.set_invalid, out_if.last);
    end
  endfunction

  always @(posedge clk) begin
    disk_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        want = '0;
        note_mismatch(want, 1'b1);
      end else begin
        want = words_due.pop_front();
        if (out_if.disk_word !== want.word || out_if.disk_number !== want.disk ||
            out_if.set_invalid !== want.invalid || out_if.last !== want.last)
          note_mismatch(want, 1'b0);
      end
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.col_bits    = '0;
    in_if.erased_mask = '0;
    in_if.set_start   = 1'b0;
    foreach (stripe_rows[i]) stripe_rows[i] = '0;
    col_pos        = '0;
    parity_pos     = '0;
    set_bad        = 1'b0;
    disk_count_reg = DISK_COUNT_RST;
    odd_reg        = 1'b0;
    block_bits_reg = BLOCK_BITS_RST;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_config_extremes();
    test_mid_block_changes();
    test_random_sets();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
